// ===== hw/rtl/lcm_pkg.sv =====
// ----------------------------------------------------------------------------
// lcm_pkg: shared types and constants of the linear crossfade mixer
// Sample and length widths, and the job record that travels from the front
// end through the queue to the arithmetic back end.
// ----------------------------------------------------------------------------
package lcm_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int LEN_W         = 16;
    localparam int NUM_W         = 32;
    localparam int PROD_W        = 33;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [LEN_W-1:0] FADE_LENGTH_RESET = 16'd2205;

    localparam logic [NUM_W-1:0] POS_LIMIT = 32'd32767;
    localparam logic [NUM_W-1:0] NEG_LIMIT = 32'd32768;

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

    // One classified sample pair, ready for the weighted mix.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] tail_sample;
        logic signed [SAMPLE_W-1:0] head_sample;
        logic [LEN_W-1:0]           length;
        logic [LEN_W-1:0]           position;
        logic                       last;
    } mix_job_t;

endpackage

// ===== hw/rtl/lcm_front.sv =====
// ----------------------------------------------------------------------------
// lcm_front: sample intake and fade position tracking
// Accept sample pairs, resolve the effective fade length and position,
// flag the last sample and push one job per pair into the queue.
// ----------------------------------------------------------------------------
module lcm_front
    import lcm_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [LEN_W-1:0]           fade_length,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] in_tail,
    input  logic signed [SAMPLE_W-1:0] in_head,
    output logic                       job_valid,
    input  logic                       job_ready,
    output mix_job_t                   job
);

    localparam int CAP_VAL = (COUNT_BITS < LEN_W) ? (1 << COUNT_BITS) : 65535;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(CAP_VAL);
    localparam int CMP_W = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;

    logic [COUNT_BITS-1:0] position_reg;
    logic [COUNT_BITS-1:0] position_next;
    logic [LEN_W-1:0]      length_eff;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      len_ext;
    logic [CMP_W-1:0]      pos_use;
    logic                  last;
    logic                  accept;

    assign in_ready  = job_ready;
    assign job_valid = in_valid;
    assign accept    = in_valid && job_ready;

    always_comb begin
        length_eff = fade_length;
        if (length_eff == '0) begin
            length_eff = LEN_W'(1);
        end
        if (length_eff > LEN_CAP) begin
            length_eff = LEN_CAP;
        end
        pos_ext = CMP_W'(position_reg);
        len_ext = CMP_W'(length_eff);
        // restart when the length was lowered to or below the current position
        pos_use = (pos_ext >= len_ext) ? '0 : pos_ext;
        last    = (pos_use == len_ext - CMP_W'(1));
        position_next = last ? '0 : COUNT_BITS'(pos_use + CMP_W'(1));
    end

    always_comb begin
        job.tail_sample = in_tail;
        job.head_sample = in_head;
        job.length      = length_eff;
        job.position    = pos_use[LEN_W-1:0];
        job.last        = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
        end else if (accept) begin
            position_reg <= position_next;
        end
    end

endmodule

// ===== hw/rtl/lcm_queue.sv =====
// ----------------------------------------------------------------------------
// lcm_queue: short job queue between front and back end
// Two-entry register queue; lets intake and arithmetic stall on their own.
// ----------------------------------------------------------------------------
module lcm_queue
    import lcm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     wr_valid,
    output logic     wr_ready,
    input  mix_job_t wr_job,
    output logic     rd_valid,
    input  logic     rd_ready,
    output mix_job_t rd_job
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    mix_job_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/lcm_back.sv =====
// ----------------------------------------------------------------------------
// lcm_back: weighted mix, iterative division and saturation
// Multiply both samples by their weights, add, divide the sum by the fade
// length one quotient bit per cycle, clamp and hold the result for output.
// ----------------------------------------------------------------------------
module lcm_back
    import lcm_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       job_valid,
    output logic                       job_ready,
    input  mix_job_t                   job,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] out_sample,
    output logic                       out_last
);

    localparam int STEP_W = $clog2(NUM_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_DIV,
        ST_HOLD
    } state_t;

    state_t                     state_reg;
    mix_job_t                   job_reg;
    logic signed [PROD_W-1:0]   prod_tail_reg;
    logic signed [PROD_W-1:0]   prod_head_reg;
    logic                       neg_reg;
    logic [NUM_W-1:0]           quot_reg;
    logic [LEN_W-1:0]           rem_reg;
    logic [STEP_W-1:0]          step_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       out_last_reg;

    logic [LEN_W-1:0]           tail_weight;
    logic signed [NUM_W-1:0]    num;
    logic [LEN_W:0]             rem_shift;
    logic                       fits;
    logic [LEN_W:0]             rem_diff;
    logic signed [SAMPLE_W-1:0] sat_value;
    logic                       out_free;

    assign job_ready  = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_last   = out_last_reg;
    assign out_free   = !out_valid_reg || out_ready;

    always_comb begin
        tail_weight = job_reg.length - job_reg.position;
        num         = NUM_W'(prod_tail_reg + prod_head_reg);
        rem_shift   = {rem_reg, quot_reg[NUM_W-1]};
        rem_diff    = rem_shift - {1'b0, job_reg.length};
        fits        = (rem_shift >= {1'b0, job_reg.length});
        // clamp the quotient magnitude; the mix stays inside the range anyway
        if (neg_reg) begin
            sat_value = (quot_reg > NEG_LIMIT) ? SAT_MIN
                                               : SAMPLE_W'(-quot_reg[SAMPLE_W-1:0]);
        end else begin
            sat_value = (quot_reg > POS_LIMIT) ? SAT_MAX
                                               : SAMPLE_W'(quot_reg[SAMPLE_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            // drop a taken result; the hand-off state reloads the register itself
            if (out_valid_reg && out_ready && (state_reg != ST_HOLD)) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        job_reg   <= job;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    prod_tail_reg <= PROD_W'(job_reg.tail_sample
                                             * $signed({1'b0, tail_weight}));
                    prod_head_reg <= PROD_W'(job_reg.head_sample
                                             * $signed({1'b0, job_reg.position}));
                    state_reg     <= ST_SUM;
                end
                ST_SUM: begin
                    neg_reg   <= num[NUM_W-1];
                    quot_reg  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
                    rem_reg   <= '0;
                    step_reg  <= STEP_W'(NUM_W - 1);
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    rem_reg  <= fits ? rem_diff[LEN_W-1:0] : rem_shift[LEN_W-1:0];
                    quot_reg <= {quot_reg[NUM_W-2:0], fits};
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0) begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        out_valid_reg  <= 1'b1;
                        out_sample_reg <= sat_value;
                        out_last_reg   <= job_reg.last;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/linear_crossfade_mixer.sv =====
// ----------------------------------------------------------------------------
// linear_crossfade_mixer: linear crossfade of two 16-bit sample streams
// Mixes the tail of an outgoing clip into the head of an incoming clip.
// ----------------------------------------------------------------------------
// Each transfer on the input stream carries one sample of the outgoing clip
// tail and one of the incoming clip head. The block returns one transfer per
// input: (tail*(N-i) + head*i)/N, truncated toward zero and clamped to 16
// bits, where N is fade_length (0 acts as 1, capped at min(2^COUNT_BITS,
// 65535)) and i the fade position. tlast marks i = N-1, after which the
// position wraps to 0. Stream exactly N sample pairs per crossfade. The
// back end loads a sample pair, multiplies, adds, runs the one-bit-per-cycle
// restoring divider and hands off the result before it takes the next pair;
// the divider sets the rate. A two-entry queue sits between intake and the
// arithmetic, and the output register holds a finished result while the
// next one is computed. Write fade_length only while the block is idle.
// ----------------------------------------------------------------------------
module linear_crossfade_mixer
    import lcm_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // fade length register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,       // [15:0] fade_length
    // sample pairs in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] tail_sample, [31:16] head_sample
    // mixed samples out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] mixed_sample
    output logic        m_axis_tlast    // fade_done
);

    logic [LEN_W-1:0]           fade_length_reg;
    logic                       fq_valid;
    logic                       fq_ready;
    mix_job_t                   fq_job;
    logic                       qb_valid;
    logic                       qb_ready;
    mix_job_t                   qb_job;
    logic signed [SAMPLE_W-1:0] mixed_sample;

    // Always take register writes; hold the length until the next write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_length_reg <= FADE_LENGTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            fade_length_reg <= cfg_data;
        end
    end

    // Intake: classify each pair and advance the fade position.
    lcm_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fade_length (fade_length_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_tail     ($signed(s_axis_tdata[15:0])),
        .in_head     ($signed(s_axis_tdata[31:16])),
        .job_valid   (fq_valid),
        .job_ready   (fq_ready),
        .job         (fq_job)
    );

    // Decouple intake from the slow divider.
    lcm_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_job   (fq_job),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_job   (qb_job)
    );

    // Arithmetic: weighted sum, division by N, clamp, output register.
    lcm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_valid  (qb_valid),
        .job_ready  (qb_ready),
        .job        (qb_job),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_sample (mixed_sample),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = mixed_sample;

endmodule
